FILE: hdl/lsw_pkg.sv
// Package for the landmark smile window detector.
// Holds widths, register indexes, verdict codes and the sequencer state types.
// No dependencies.
package lsw_pkg;
	localparam int WINDOW = 16;
	localparam int COORD_BITS = 12;
	localparam int WIN_BITS = $clog2(WINDOW);
	localparam int CNT_BITS = $clog2(WINDOW + 1);
	localparam int NEW_CNT = WINDOW / 2;
	localparam int OLD_CNT = WINDOW - WINDOW / 2 - 1;
	localparam int SQ_BITS = 2 * COORD_BITS + 1;
	localparam int SUM_BITS = 16 + WIN_BITS;
	localparam int GAIN_BITS = 10;

	localparam logic [0:0] REG_LIP_GAIN = 1'b0;
	localparam logic [0:0] REG_CORNER_GAIN = 1'b1;

	localparam logic [1:0] VERDICT_FEW = 2'd0;
	localparam logic [1:0] VERDICT_LIPS = 2'd1;
	localparam logic [1:0] VERDICT_WIDTH = 2'd2;
	localparam logic [1:0] VERDICT_SMILE = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIST, ST_DIV_W, ST_SQRT_W, ST_DIV_O, ST_SQRT_O,
		ST_SUM, ST_CMP, ST_OUT
	} state_t;

	// Phases of the shared ratio unit.
	typedef enum logic [1:0] {
		PH_IDLE, PH_DIV, PH_ROOT
	} phase_t;
endpackage

FILE: hdl/lsw_ratio_unit.sv
// Ratio unit: floor(sqrt(65536*a/b)) with saturation, one bit per cycle.
// Restoring divider followed by a digit-by-digit square root. Uses lsw_pkg.
module lsw_ratio_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [lsw_pkg::SQ_BITS-1:0] num_sq,
	input  logic [lsw_pkg::SQ_BITS-1:0] den_sq,
	output logic done,
	output logic [15:0] ratio
);
	import lsw_pkg::*;
	localparam int QB = SQ_BITS + 16;
	localparam int QCB = $clog2(QB + 1);

	phase_t phase_q, phase_d;
	logic [QCB-1:0] cnt_q;
	logic [QB-1:0] dividend_q;
	logic [SQ_BITS:0] rem_q;
	logic [QB-1:0] quot_q;
	logic [33:0] root_rem_q;
	logic [15:0] root_q;
	logic [4:0] rcnt_q;
	logic [SQ_BITS:0] rem_sh;
	logic [33:0] rr_sh, trial;

	assign rem_sh = {rem_q[SQ_BITS-1:0], dividend_q[QB-1]};
	assign rr_sh = {root_rem_q[31:0], quot_q[31:30]};
	assign trial = {16'd0, root_q, 2'b01};

	// Next phase: divide for every quotient bit, then root for 16 result bits.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: if (start && den_sq != '0) phase_d = PH_DIV;
			PH_DIV: if (cnt_q == QCB'(QB - 1)) phase_d = PH_ROOT;
			PH_ROOT: if (rcnt_q == 5'd15) phase_d = PH_IDLE;
			default: phase_d = PH_IDLE;
		endcase
	end

	// Phase register and the done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done <= (phase_q == PH_IDLE && start && den_sq == '0) ||
				(phase_q == PH_ROOT && rcnt_q == 5'd15);
		end
	end

	// Datapath: one divide bit or one root bit per cycle.
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				dividend_q <= {num_sq, 16'd0};
				rem_q <= '0;
				quot_q <= '0;
				cnt_q <= '0;
				rcnt_q <= '0;
				root_q <= '0;
				root_rem_q <= '0;
				if (start && den_sq == '0) ratio <= 16'hFFFF;
			end
			PH_DIV: begin
				dividend_q <= dividend_q << 1;
				cnt_q <= cnt_q + 1'b1;
				if (rem_sh >= {1'b0, den_sq}) begin
					rem_q <= rem_sh - {1'b0, den_sq};
					quot_q <= {quot_q[QB-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quot_q <= {quot_q[QB-2:0], 1'b0};
				end
			end
			PH_ROOT: begin
				// The upper quotient bits stay put for the overflow check.
				quot_q <= {quot_q[QB-1:32], quot_q[29:0], 2'b00};
				rcnt_q <= rcnt_q + 1'b1;
				if (rr_sh >= trial) begin
					root_rem_q <= rr_sh - trial;
					root_q <= {root_q[14:0], 1'b1};
				end else begin
					root_rem_q <= rr_sh;
					root_q <= {root_q[14:0], 1'b0};
				end
				if (rcnt_q == 5'd15) begin
					if (quot_q[QB-1:32] != '0) ratio <= 16'hFFFF;
					else if (rr_sh >= trial) ratio <= {root_q[14:0], 1'b1};
					else ratio <= {root_q[14:0], 1'b0};
				end
			end
			default: ;
		endcase
	end
endmodule

FILE: hdl/landmark_smile_window_detector.sv
// Landmark smile window detector, top level.
// Holds the sequencer, ratio history and the shared sum/compare datapath.
// Uses lsw_pkg and lsw_ratio_unit.
//
// Usage: items enter on s_axis (tdata packs command then six 24-bit points).
// Each item yields one result on m_axis: tdata bits 1:0 verdict, bit 2 smile.
// A no-face item goes from idle straight to the OUT state, which then sets the
// output register. A face frame runs two ratios through the shared divide/root
// unit; once the window is full it then sums both windows one entry a cycle
// and compares in two multiply steps. The next item can be taken once the
// result has left. s_axis_tready is high only when idle and the output
// register is empty; a stalled receiver holds the result and the block waits.
// Reset empties the output, clears the frame count and loads the default gains;
// the history contents are left undefined. Configuration writes go through
// cfg_we/cfg_index/cfg_data; the user must make them only while idle, as the
// block itself does not enforce it.
module landmark_smile_window_detector (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [9:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// command[0], mouth_left[24:1], mouth_right[48:25], top_lip[72:49],
	// low_lip[96:73], left_reference[120:97], right_reference[144:121], zero pad
	input  logic [151:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// verdict[1:0], smile[2], zero pad
	output logic [7:0] m_axis_tdata
);
	import lsw_pkg::*;

	state_t state_q, state_d;
	logic [GAIN_BITS-1:0] lip_gain_q, corner_gain_q;
	logic [CNT_BITS-1:0] frames_q;
	logic [143:0] pts_q;
	logic [SQ_BITS-1:0] dw_q, do_q, dn_q;
	logic [15:0] wr_q;
	logic [15:0] wh_q [WINDOW];
	logic [15:0] oh_q [WINDOW];
	logic [WIN_BITS:0] idx_q;
	logic [SUM_BITS-1:0] wnew_q, wold_q, onew_q, oold_q;
	logic [1:0] verdict_q;
	logic out_valid_q;
	logic lip_fail_q;
	logic unit_start;
	logic unit_done;
	logic [SQ_BITS-1:0] unit_num;
	logic [15:0] ratio;
	logic [3:0] step_q;

	function automatic logic [SQ_BITS-1:0] sqd(input logic [23:0] p, input logic [23:0] q);
		logic [COORD_BITS-1:0] dx, dy;
		dx = (p[COORD_BITS-1:0] > q[COORD_BITS-1:0]) ?
			p[COORD_BITS-1:0] - q[COORD_BITS-1:0] : q[COORD_BITS-1:0] - p[COORD_BITS-1:0];
		dy = (p[2*COORD_BITS-1:COORD_BITS] > q[2*COORD_BITS-1:COORD_BITS]) ?
			p[2*COORD_BITS-1:COORD_BITS] - q[2*COORD_BITS-1:COORD_BITS] :
			q[2*COORD_BITS-1:COORD_BITS] - p[2*COORD_BITS-1:COORD_BITS];
		return SQ_BITS'(dx) * SQ_BITS'(dx) + SQ_BITS'(dy) * SQ_BITS'(dy);
	endfunction

	// Shared ratio unit, started on entry to each divide state.
	assign unit_num = (state_q == ST_DIV_W) ? dw_q : do_q;
	lsw_ratio_unit u_ratio (
		.clk(clk), .arst_n(arst_n), .start(unit_start),
		.num_sq(unit_num), .den_sq(dn_q), .done(unit_done), .ratio(ratio)
	);

	assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {5'd0, verdict_q == VERDICT_SMILE, verdict_q};

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_axis_tvalid && s_axis_tready)
				state_d = s_axis_tdata[0] ? ST_OUT : ST_DIST;
			ST_DIST: state_d = ST_DIV_W;
			ST_DIV_W: state_d = ST_SQRT_W;
			ST_SQRT_W: if (unit_done) state_d = ST_DIV_O;
			ST_DIV_O: state_d = ST_SQRT_O;
			ST_SQRT_O: if (unit_done) state_d = (frames_q == CNT_BITS'(WINDOW)) ?
				ST_SUM : ST_OUT;
			ST_SUM: if (idx_q == (WIN_BITS + 1)'(WINDOW - 1)) state_d = ST_CMP;
			ST_CMP: if (step_q == 4'd1) state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Output decode for the sequencer.
	always_comb begin
		unit_start = (state_q == ST_DIV_W) || (state_q == ST_DIV_O);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lip_gain_q <= 10'd384;
			corner_gain_q <= 10'd333;
			frames_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == REG_LIP_GAIN) lip_gain_q <= cfg_data;
			if (cfg_we && cfg_index == REG_CORNER_GAIN) corner_gain_q <= cfg_data;
			if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tdata[0]) frames_q <= '0;
				else if (frames_q != CNT_BITS'(WINDOW)) frames_q <= frames_q + 1'b1;
			end
			if (state_q == ST_OUT) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// Datapath: distances, history shift, window sums and comparison.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				pts_q <= s_axis_tdata[144:1];
				// The verdict of a waiting result stays until a new item is taken.
				if (s_axis_tvalid && s_axis_tready) verdict_q <= VERDICT_FEW;
				idx_q <= '0;
				step_q <= '0;
				wnew_q <= '0; wold_q <= '0; onew_q <= '0; oold_q <= '0;
			end
			ST_DIST: begin
				dw_q <= sqd(pts_q[23:0], pts_q[47:24]);
				do_q <= sqd(pts_q[71:48], pts_q[95:72]);
				dn_q <= sqd(pts_q[119:96], pts_q[143:120]);
			end
			ST_SQRT_W: if (unit_done) wr_q <= ratio;
			ST_SQRT_O: if (unit_done) begin
				for (int i = WINDOW - 1; i > 0; i--) begin
					wh_q[i] <= wh_q[i-1];
					oh_q[i] <= oh_q[i-1];
				end
				wh_q[0] <= wr_q;
				oh_q[0] <= ratio;
			end
			ST_SUM: begin
				idx_q <= idx_q + 1'b1;
				if (idx_q < (WIN_BITS + 1)'(NEW_CNT)) begin
					wnew_q <= wnew_q + SUM_BITS'(wh_q[idx_q[WIN_BITS-1:0]]);
					onew_q <= onew_q + SUM_BITS'(oh_q[idx_q[WIN_BITS-1:0]]);
				end else if (idx_q > (WIN_BITS + 1)'(NEW_CNT)) begin
					wold_q <= wold_q + SUM_BITS'(wh_q[idx_q[WIN_BITS-1:0]]);
					oold_q <= oold_q + SUM_BITS'(oh_q[idx_q[WIN_BITS-1:0]]);
				end
			end
			ST_CMP: begin
				step_q <= step_q + 1'b1;
				if (step_q == 4'd0) begin
					lip_fail_q <= (64'(lip_gain_q) * 64'(oold_q) * 64'(NEW_CNT)) >
						(64'(onew_q) * 64'(256 * OLD_CNT));
				end else begin
					verdict_q <= lip_fail_q ? VERDICT_LIPS :
						((64'(corner_gain_q) * 64'(wold_q) * 64'(NEW_CNT)) >
						(64'(wnew_q) * 64'(256 * OLD_CNT))) ? VERDICT_WIDTH : VERDICT_SMILE;
				end
			end
			default: ;
		endcase
	end

	// A result only appears after the OUT state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT) else $error("stray result");
	// Any verdict other than too few frames, a smile included, needs a full window.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q != VERDICT_FEW) |-> frames_q == CNT_BITS'(WINDOW))
		else $error("verdict without full window");
	// No new item while a result waits.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !s_axis_tready) else $error("accept while holding");
endmodule
